/* hw/rtl/stapd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STAP-A deaggregator package
// Shared types and constants: word structs, parse phases and status codes.
// ----------------------------------------------------------------------------
package stapd_pkg;

  localparam logic [7:0] FORBIDDEN_BIT = 8'h80;
  localparam logic [7:0] NRI_MASK      = 8'hE0;
  localparam logic       CODEC_DEFAULT = 1'b0;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_LENHI  = 3'd2,
    PH_LENLO  = 3'd3,
    PH_DFIRST = 3'd4,
    PH_DREST  = 3'd5,
    PH_DROP   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FORBIDDEN  = 3'd1,
    ST_TRUNC_LEN  = 3'd2,
    ST_TRUNC_UNIT = 3'd3,
    ST_TRUNC_HDR  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] unit_byte;
    logic       byte_valid;
    logic       unit_first;
    logic       unit_last;
    logic [5:0] unit_type;
    logic       first_param_set;
    logic [7:0] header_info;
    logic       header_valid;
    logic [2:0] status;
    logic       packet_done;
  } out_word_t;

endpackage

/* hw/rtl/stap_packet_deaggregator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STAP-A packet deaggregator (H.264 / H.265)
// Splits aggregation packets into unit bytes with unit marks, type and status.
// ----------------------------------------------------------------------------
// Path: an accepted word waits in the input register, and its result word is
// written to the result register; an out_ready stall can hold both registers.
// Throughput: 1 word per cycle unless out_ready stalls; the parse state updates
// once per word in a single pass between the input and result registers.
// Reset: synchronous active-low; clears the parse state and both registers'
// valid flags and sets codec_mode to H.264. Configuration is always ready.
module stap_packet_deaggregator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stapd_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stapd_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  logic                 codec_mode_r;
  logic                 in_full;
  stapd_pkg::in_word_t  in_word;
  stapd_pkg::out_word_t result;
  logic                 move;
  logic                 out_valid_r;
  stapd_pkg::out_word_t out_data_r;

  assign cfg_ready = 1'b1;
  assign move      = in_full && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= stapd_pkg::CODEC_DEFAULT;
    end else if (cfg_valid) begin
      codec_mode_r <= cfg_data;
    end
  end

  stapd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (move),
    .full     (in_full),
    .word     (in_word)
  );

  stapd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (move),
    .codec_mode (codec_mode_r),
    .word       (in_word),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= result;
    end
  end

  // A completed header is never reported together with an error.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.header_valid |-> out_data_r.status == stapd_pkg::ST_OK)
    else $error("header_valid with error status");

  // A first parameter set flag only appears on the first data byte of a unit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.first_param_set |->
      out_data_r.unit_first && out_data_r.byte_valid)
    else $error("first_param_set off a first data byte");

  // Truncation errors are only raised on the packet's end byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == stapd_pkg::ST_TRUNC_LEN ||
                    out_data_r.status == stapd_pkg::ST_TRUNC_UNIT ||
                    out_data_r.status == stapd_pkg::ST_TRUNC_HDR) |->
      out_data_r.packet_done)
    else $error("truncation status without end of packet");

  // Only a truncated unit may carry a data byte alongside an error.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.byte_valid |->
      (out_data_r.status == stapd_pkg::ST_OK ||
       out_data_r.status == stapd_pkg::ST_TRUNC_UNIT))
    else $error("data byte with unexpected status");

endmodule

/* hw/rtl/stapd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STAP-A deaggregator input register
// Holds one accepted word until the parser consumes it.
// ----------------------------------------------------------------------------
module stapd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  stapd_pkg::in_word_t in_data,
  input  logic               take,
  output logic               full,
  output stapd_pkg::in_word_t word
);

  logic                full_r;
  stapd_pkg::in_word_t word_r;

  // The register frees up in the same cycle its word moves on.
  assign in_ready = !full_r || take;
  assign full     = full_r;
  assign word     = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_ready) begin
      full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_data;
    end
  end

endmodule

/* hw/rtl/stapd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STAP-A deaggregator parser
// Packet parse state and the single-pass logic that turns one payload word
// into one result word.
// ----------------------------------------------------------------------------
module stapd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 codec_mode,
  input  stapd_pkg::in_word_t  word,
  output stapd_pkg::out_word_t result
);

  stapd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]        lenhi_r, lenhi_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [15:0]       rem_dec;
  logic [5:0]        cur_r, cur_nxt;
  logic [2:0]        seen_r, seen_nxt;
  logic [5:0]        first_type;
  logic [2:0]        pbit;
  logic [7:0]        b;
  logic              pend;

  // Bit 0 SPS, bit 1 PPS, bit 2 VPS.
  function automatic logic [2:0] param_bit(input logic mode, input logic [5:0] typ);
    logic [2:0] r;
    r = 3'b000;
    if (!mode) begin
      if (typ == 6'd7) r = 3'b001;
      if (typ == 6'd8) r = 3'b010;
    end else begin
      if (typ == 6'd33) r = 3'b001;
      if (typ == 6'd34) r = 3'b010;
      if (typ == 6'd32) r = 3'b100;
    end
    return r;
  endfunction

  assign b          = word.in_byte;
  assign pend       = word.packet_end;
  assign rem_dec    = rem_r - 16'd1;
  assign first_type = codec_mode ? b[6:1] : {1'b0, b[4:0]};
  assign pbit       = param_bit(codec_mode, first_type);

  always_comb begin
    phase_nxt = phase_r;
    lenhi_nxt = lenhi_r;
    rem_nxt   = rem_r;
    cur_nxt   = cur_r;
    seen_nxt  = seen_r;
    result    = '0;
    case (phase_r)
      stapd_pkg::PH_HDR0: begin
        if (!codec_mode) begin
          if ((b & stapd_pkg::FORBIDDEN_BIT) != 8'h00) begin
            result.status = stapd_pkg::ST_FORBIDDEN;
            phase_nxt     = stapd_pkg::PH_DROP;
          end else begin
            result.header_info  = b & stapd_pkg::NRI_MASK;
            result.header_valid = 1'b1;
            phase_nxt           = stapd_pkg::PH_LENHI;
          end
        end else begin
          cur_nxt = b[6:1];
          if (pend) begin
            result.status = stapd_pkg::ST_TRUNC_HDR;
          end else begin
            phase_nxt = stapd_pkg::PH_HDR1;
          end
        end
      end
      stapd_pkg::PH_HDR1: begin
        // The second H.265 header byte only completes the header.
        result.header_info  = {2'b00, cur_r};
        result.header_valid = 1'b1;
        cur_nxt             = 6'd0;
        phase_nxt           = stapd_pkg::PH_LENHI;
      end
      stapd_pkg::PH_LENHI: begin
        lenhi_nxt = b;
        if (pend) begin
          result.status = stapd_pkg::ST_TRUNC_LEN;
        end else begin
          phase_nxt = stapd_pkg::PH_LENLO;
        end
      end
      stapd_pkg::PH_LENLO: begin
        rem_nxt = {lenhi_r, b};
        if (lenhi_r == 8'h00 && b == 8'h00) begin
          result.unit_first = 1'b1;
          result.unit_last  = 1'b1;
          phase_nxt         = stapd_pkg::PH_LENHI;
        end else if (pend) begin
          result.status = stapd_pkg::ST_TRUNC_UNIT;
        end else begin
          phase_nxt = stapd_pkg::PH_DFIRST;
        end
      end
      stapd_pkg::PH_DFIRST, stapd_pkg::PH_DREST: begin
        if (phase_r == stapd_pkg::PH_DFIRST) begin
          cur_nxt           = first_type;
          result.unit_type  = first_type;
          result.unit_first = 1'b1;
          if (pbit != 3'b000 && (seen_r & pbit) == 3'b000) begin
            result.first_param_set = 1'b1;
            seen_nxt               = seen_r | pbit;
          end
        end else begin
          result.unit_type = cur_r;
        end
        result.unit_byte  = b;
        result.byte_valid = 1'b1;
        rem_nxt           = rem_dec;
        if (rem_dec == 16'd0) begin
          result.unit_last = 1'b1;
          phase_nxt        = stapd_pkg::PH_LENHI;
        end else if (pend) begin
          result.status = stapd_pkg::ST_TRUNC_UNIT;
        end else begin
          phase_nxt = stapd_pkg::PH_DREST;
        end
      end
      default: begin
        // Bytes after an error are dropped until the end mark.
        phase_nxt = stapd_pkg::PH_DROP;
      end
    endcase

    if (pend) begin
      result.packet_done = 1'b1;
      phase_nxt          = stapd_pkg::PH_HDR0;
      lenhi_nxt          = 8'h00;
      rem_nxt            = 16'd0;
      cur_nxt            = 6'd0;
      seen_nxt           = 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= stapd_pkg::PH_HDR0;
      lenhi_r <= 8'h00;
      rem_r   <= 16'd0;
      cur_r   <= 6'd0;
      seen_r  <= 3'b000;
    end else if (step) begin
      phase_r <= phase_nxt;
      lenhi_r <= lenhi_nxt;
      rem_r   <= rem_nxt;
      cur_r   <= cur_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule
